FILE: rtl/core/ptf_pkg.sv
// Package: shared types and constants of the prompt track fraction unit.
`default_nettype none
package ptf_pkg;

  // Item codes
  localparam logic OP_JET   = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_RADIUS_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_CUT_ENABLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_WINDOW_UM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_Z_UM    = 2'd3;

  // Register reset values
  localparam logic [31:0] CONE_RADIUS_SQ_RST = 32'd24159191;
  localparam logic        Z_CUT_ENABLE_RST   = 1'b1;
  localparam logic [18:0] Z_WINDOW_UM_RST    = 19'd10000;
  localparam logic [19:0] VERTEX_Z_UM_RST    = 20'd0;

  // Track quality cuts
  localparam logic signed [19:0] D0_MAX      = 20'sd300000;
  localparam logic signed [19:0] DZ_MAX      = 20'sd500000;
  localparam logic [19:0]        PT_MIN      = 20'd1000;
  localparam logic signed [15:0] ETA_MAX     = 16'sd12288;
  localparam logic signed [15:0] ETA_MIN     = -16'sd12288;
  localparam logic [28:0]        D0_CUT_BASE = 29'd463000;
  localparam logic [28:0]        D0_CUT_SLOPE = 29'd195;

  // Shared multiplier and divider
  localparam int unsigned MUL_W    = 21;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned SUM_W    = 30;
  localparam int unsigned JPT_W    = 20;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam logic [SUM_W-1:0]  PT_SUM_MAX = {SUM_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_MAX   = {FRAC_W{1'b1}};

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] eta;
    logic signed [15:0] phi;
    logic [19:0]        pt;
    logic signed [19:0] d0_um;
    logic signed [19:0] dz_um;
    logic               last;
  } ptf_in_t;

  typedef struct packed {
    logic [23:0] fraction;
    logic [10:0] used_tracks;
  } ptf_out_t;

endpackage
`default_nettype wire

FILE: rtl/core/prompt_track_fraction_unit.sv
// Top level: track cuts, pt accumulation and fraction output of one jet.
`default_nettype none
// A jet beat (opcode jet) loads the jet axis and pt and clears the running sum and
// count. In a track beat one multiplier is shared for the eta distance square, the
// phi distance square and the d0 times pt product, and the cuts and accumulation
// settle in a fourth step. A beat with last set then runs the one-bit-per-cycle
// divider: 24 steps, or none when the fraction saturates (zero or small jet pt).
// The result sits in an output register, so the next beat is taken while it waits;
// a second result waits for that register to drain. Configuration writes take
// effect at once.
module prompt_track_fraction_unit
  import ptf_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = 1024
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ptf_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ptf_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_MUL_DE   = 8'b0000_0010,
    ST_MUL_DP   = 8'b0000_0100,
    ST_MUL_D0   = 8'b0000_1000,
    ST_CHECK    = 8'b0001_0000,
    ST_DIV_GO   = 8'b0010_0000,
    ST_DIV_WAIT = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [31:0]        cone_radius_sq;
  logic               z_cut_enable;
  logic [18:0]        z_window_um;
  logic signed [19:0] vertex_z_um;

  // Jet state
  logic signed [15:0] jet_eta;
  logic signed [15:0] jet_phi;
  logic [JPT_W-1:0]   jet_pt;
  logic [SUM_W-1:0]   pt_sum;
  logic [CNT_W-1:0]   track_count;

  ptf_in_t item;
  logic    in_fire;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [33:0]              dist_sq;

  logic signed [16:0] de;
  logic signed [16:0] dp;
  logic [28:0]        d0_rhs;
  logic signed [PROD_W+1:0] d0_lhs;
  logic signed [20:0] dzv;
  logic [20:0]        dz_abs;
  logic               pass_quality;
  logic               pass_cone;
  logic               pass_d0;
  logic               pass_z;
  logic               take_track;
  logic [SUM_W:0]     sum_wide;

  logic               div_start;
  logic               div_done;
  logic [FRAC_W-1:0]  div_quot;
  logic               emit_go;

  assign in_ready  = state == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign div_start = state == ST_DIV_GO;
  assign emit_go   = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cone_radius_sq <= CONE_RADIUS_SQ_RST;
      z_cut_enable   <= Z_CUT_ENABLE_RST;
      z_window_um    <= Z_WINDOW_UM_RST;
      vertex_z_um    <= VERTEX_Z_UM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONE_RADIUS_SQ: cone_radius_sq <= cfg_data;
        REG_Z_CUT_ENABLE:   z_cut_enable   <= cfg_data[0];
        REG_Z_WINDOW_UM:    z_window_um    <= cfg_data[18:0];
        REG_VERTEX_Z_UM:    vertex_z_um    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier
  assign de = 17'(item.eta) - 17'(jet_eta);
  assign dp = 17'(item.phi) - 17'(jet_phi);

  always_comb begin
    case (state)
      ST_MUL_DE: begin
        mul_a = MUL_W'(de);
        mul_b = MUL_W'(de);
      end
      ST_MUL_DP: begin
        mul_a = MUL_W'(dp);
        mul_b = MUL_W'(dp);
      end
      default: begin
        mul_a = MUL_W'(item.d0_um);
        mul_b = $signed({1'b0, item.pt});
      end
    endcase
  end

  ptf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Accumulate the squared distance from the pipelined products
  always_ff @(posedge clk) begin
    case (state)
      ST_MUL_DP: dist_sq <= {1'b0, prod[32:0]};
      ST_MUL_D0: dist_sq <= dist_sq + {1'b0, prod[32:0]};
      default:   dist_sq <= dist_sq;
    endcase
  end

  // Cuts, evaluated in the check step
  assign pass_quality = (item.d0_um < D0_MAX) && (item.dz_um < DZ_MAX) &&
                        (item.pt > PT_MIN) && (item.eta < ETA_MAX) &&
                        (item.eta > ETA_MIN);
  assign pass_cone    = dist_sq < {2'b00, cone_radius_sq};
  assign d0_rhs       = D0_CUT_BASE + 29'(item.pt) * D0_CUT_SLOPE;
  assign d0_lhs       = {prod, 2'b00};
  assign pass_d0      = d0_lhs < $signed({{(PROD_W - 27){1'b0}}, d0_rhs});
  assign dzv          = 21'(vertex_z_um) - 21'(item.dz_um);
  assign dz_abs       = dzv[20] ? 21'(-dzv) : 21'(dzv);
  assign pass_z       = !z_cut_enable || (dz_abs < {2'b00, z_window_um});
  assign take_track   = pass_quality && pass_cone && pass_d0 && pass_z &&
                        (track_count < CNT_W'(MAX_TRACKS));
  assign sum_wide     = {1'b0, pt_sum} + (SUM_W + 1)'(item.pt);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jet_eta     <= '0;
      jet_phi     <= '0;
      jet_pt      <= '0;
      pt_sum      <= '0;
      track_count <= '0;
    end else if (in_fire && in_data.opcode == OP_JET) begin
      jet_eta     <= in_data.eta;
      jet_phi     <= in_data.phi;
      jet_pt      <= in_data.pt;
      pt_sum      <= '0;
      track_count <= '0;
    end else if (state == ST_CHECK && take_track) begin
      pt_sum      <= sum_wide[SUM_W] ? PT_SUM_MAX : sum_wide[SUM_W-1:0];
      track_count <= track_count + CNT_W'(1);
    end
  end

  ptf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pt_sum),
    .divisor  (jet_pt),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.opcode == OP_TRACK) begin
            state_next = ST_MUL_DE;
          end else if (in_data.last) begin
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_MUL_DE:   state_next = ST_MUL_DP;
      ST_MUL_DP:   state_next = ST_MUL_D0;
      ST_MUL_D0:   state_next = ST_CHECK;
      ST_CHECK:    state_next = item.last ? ST_DIV_GO : ST_IDLE;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: state_next = div_done ? ST_EMIT : ST_DIV_WAIT;
      ST_EMIT:     state_next = emit_go ? ST_IDLE : ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.fraction    <= div_quot;
      out_data.used_tracks <= 11'(track_count);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    track_count <= CNT_W'(MAX_TRACKS))
    else $error("track count above limit");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_jet_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.opcode == OP_JET |=> track_count == '0 && pt_sum == '0)
    else $error("jet beat did not clear the sums");

  a_sum_only_in_check: assert property (@(posedge clk) disable iff (rst)
    !in_fire && state != ST_CHECK |=> $stable(pt_sum) && $stable(track_count))
    else $error("running sum changed outside the check step");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> !out_valid || out_ready)
    else $error("result written over a waiting beat");

endmodule
`default_nettype wire

FILE: rtl/core/ptf_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module ptf_mul
  import ptf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

FILE: rtl/core/ptf_div.sv
// Bit-serial restoring divider for the Q8.16 fraction, with saturation.
`default_nettype none
module ptf_div
  import ptf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [JPT_W-1:0]  divisor,
  output logic                   done,
  output logic [FRAC_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic [CNT_W-1:0]  step;
  logic [JPT_W:0]    rem;
  logic [FRAC_W-1:0] low_bits;
  logic [JPT_W-1:0]  dvs;
  logic [JPT_W:0]    trial;
  logic [JPT_W:0]    diff;
  logic              fits;
  logic              saturate;

  // Quotient exceeds 24 bits iff dividend >= divisor * 2^8; covers a zero divisor too.
  assign saturate = dividend >= {2'b00, divisor, 8'h00};
  assign trial    = {rem[JPT_W-1:0], low_bits[FRAC_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !saturate;
        done <= saturate;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      // Upper dividend bits are already below the divisor when not saturating.
      rem      <= {1'b0, dividend[JPT_W+7:8]};
      low_bits <= {dividend[7:0], 16'h0000};
      quotient <= saturate ? FRAC_MAX : '0;
    end else if (busy) begin
      rem      <= fits ? diff : trial;
      low_bits <= {low_bits[FRAC_W-2:0], 1'b0};
      quotient <= {quotient[FRAC_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire
